>>> src/bba_pkg.sv
// Shared types, codes and helpers for the buddy block allocator.
// Depends on nothing; the sequencer, the top level, the checker and the testbench import it.
`timescale 1ns / 1ps

package bba_pkg;

  // Default memory size in units.
  localparam int TOTAL_UNITS_DEF = 64;
  // Order and depth width, and compare width, both cover up to 1024 units.
  localparam int ORD_W = 4;
  localparam int CAP_W = 11;

  // Per-node state of the block tree.
  typedef enum logic [1:0] {
    NS_ABSENT = 2'd0,
    NS_FREE   = 2'd1,
    NS_ALLOC  = 2'd2,
    NS_SPLIT  = 2'd3
  } node_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_FREED    = 3'd2,
    ST_REJECTED = 3'd3,
    ST_BAD_SIZE = 3'd4
  } status_t;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_ARD, S_ACHK, S_BRD, S_BCHK,
    S_SPLIT_P, S_SPLIT_L, S_SPLIT_R, S_AMARK,
    S_FRD, S_FCHK,
    S_MFREE, S_MRD, S_MCHK, S_MABS_I, S_MABS_B,
    S_DONE
  } bba_state_t;

  typedef struct packed {
    logic       operation;
    logic [6:0] request_size;
    logic [5:0] free_address;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] block_address;
    logic [2:0] block_order;
    logic [5:0] unused_units;
  } rsp_t;

  // Handshake view of the sequencer for the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // Smallest order whose block holds req units.
  function automatic logic [ORD_W-1:0] ceil_log2(input logic [6:0] req);
    logic [ORD_W-1:0] ord;
    ord = '0;
    for (int k = 0; k < 7; k++) begin
      if ((8'(1) << ord) < {1'b0, req}) ord = ord + 1'b1;
    end
    return ord;
  endfunction

endpackage

>>> src/bba_req_if.sv
// Request channel interface: valid/ready handshake with the request fields.
// Standalone; used by the top level's input port.
`timescale 1ns / 1ps

interface bba_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [6:0] request_size;
  logic [5:0] free_address;

  modport source (output valid, operation, request_size, free_address, input ready);
  modport sink   (input valid, operation, request_size, free_address, output ready);
endinterface

>>> src/bba_rsp_if.sv
// Result channel interface: valid/ready handshake with the result fields.
// Standalone; used by the top level's output port.
`timescale 1ns / 1ps

interface bba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] block_address;
  logic [2:0] block_order;
  logic [5:0] unused_units;

  modport source (output valid, status, block_address, block_order, unused_units,
                  input ready);
  modport sink   (input valid, status, block_address, block_order, unused_units,
                  output ready);
endinterface

>>> src/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the node tree of the allocator.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> src/bba_seq.sv
// Sequencer of the allocator: walks the node tree one node at a time, with a read step and a check step per node.
// Depends on bba_pkg; drives the node RAM through its ports.
`timescale 1ns / 1ps

module bba_seq
  import bba_pkg::*;
#(
  parameter int TOTAL_UNITS = TOTAL_UNITS_DEF,
  localparam int TOP = $clog2(TOTAL_UNITS + 1) - 1,
  localparam int NW  = TOP + 1,
  localparam int AW  = TOP
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  item_t         item,
  input  logic          rsp_free,
  output seq_stat_t     stat,
  output rsp_t          res,
  output logic          mem_we,
  output logic [NW-1:0] mem_waddr,
  output node_t         mem_wdata,
  output logic [NW-1:0] mem_raddr,
  input  node_t         mem_rdata
);

  bba_state_t       state_r, state_nxt;
  logic [NW-1:0]    node_r, node_nxt;
  logic [ORD_W-1:0] depth_r, depth_nxt;
  logic [ORD_W-1:0] dtgt_r, dtgt_nxt;
  logic [ORD_W-1:0] ord_r, ord_nxt;
  logic [6:0]       req_r, req_nxt;
  logic [5:0]       faddr_r, faddr_nxt;
  logic [NW-1:0]    best_r, best_nxt;
  logic [AW-1:0]    baddr_r, baddr_nxt;
  logic [ORD_W-1:0] bdepth_r, bdepth_nxt;
  logic             bok_r, bok_nxt;
  rsp_t             res_r, res_nxt;

  logic             eor;
  logic [AW-1:0]    cur_addr;
  logic [ORD_W-1:0] sh;
  logic [CAP_W-1:0] fa;
  logic             f_aligned;
  logic [NW-1:0]    fnode;
  logic [ORD_W-1:0] ord_in;
  logic             bad_size;
  logic             bad_addr;
  logic             take;
  logic [AW-1:0]    grant_addr;
  logic [7:0]       unused;

  // Shared address and shift arithmetic.
  always_comb begin
    eor        = (node_r & (node_r + NW'(1))) == '0;
    sh         = ORD_W'(TOP) - depth_r;
    cur_addr   = AW'(node_r - (NW'(1) << depth_r)) << sh;
    fa         = CAP_W'(faddr_r);
    f_aligned  = (fa & ((CAP_W'(1) << sh) - CAP_W'(1))) == '0;
    fnode      = (NW'(1) << depth_r) + NW'(fa >> sh);
    ord_in     = ceil_log2(item.request_size);
    bad_size   = (item.request_size == '0) ||
                 (CAP_W'(item.request_size) > (CAP_W'(1) << TOP));
    bad_addr   = (CAP_W'(item.free_address) >> TOP) != '0;
    take       = (mem_rdata == NS_FREE) && (!bok_r || (cur_addr < baddr_r));
    grant_addr = AW'(node_r - (NW'(1) << dtgt_r)) << ord_r;
    unused     = (8'(1) << ord_r) - {1'b0, req_r};
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      node_r  <= '0;
      bok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      node_r  <= node_nxt;
      bok_r   <= bok_nxt;
    end
    depth_r  <= depth_nxt;
    dtgt_r   <= dtgt_nxt;
    ord_r    <= ord_nxt;
    req_r    <= req_nxt;
    faddr_r  <= faddr_nxt;
    best_r   <= best_nxt;
    baddr_r  <= baddr_nxt;
    bdepth_r <= bdepth_nxt;
    res_r    <= res_nxt;
  end

  // Next state, datapath updates and node RAM accesses.
  always_comb begin
    state_nxt  = state_r;
    node_nxt   = node_r;
    depth_nxt  = depth_r;
    dtgt_nxt   = dtgt_r;
    ord_nxt    = ord_r;
    req_nxt    = req_r;
    faddr_nxt  = faddr_r;
    best_nxt   = best_r;
    baddr_nxt  = baddr_r;
    bdepth_nxt = bdepth_r;
    bok_nxt    = bok_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = node_r;
    mem_wdata  = NS_ABSENT;
    mem_raddr  = node_r;
    stat.idle  = 1'b0;
    stat.done  = 1'b0;

    case (state_r)
      // Sweep the tree after reset: root free, all others absent.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (node_r == NW'(1)) ? NS_FREE : NS_ABSENT;
        node_nxt  = node_r + NW'(1);
        if (node_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        stat.idle = 1'b1;
        res_nxt   = '{status: ST_GRANTED, default: '0};
        req_nxt   = item.request_size;
        faddr_nxt = item.free_address;
        ord_nxt   = ord_in;
        dtgt_nxt  = ORD_W'(TOP) - ord_in;
        depth_nxt = '0;
        if (start) begin
          if (item.operation == OP_ALLOC) begin
            if (bad_size) begin
              res_nxt.status = ST_BAD_SIZE;
              state_nxt      = S_DONE;
            end else begin
              node_nxt  = NW'(1) << (ORD_W'(TOP) - ord_in);
              state_nxt = S_ARD;
            end
          end else begin
            if (bad_addr) begin
              res_nxt.status = ST_REJECTED;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_FRD;
            end
          end
        end
      end
      // Look for a free block of exactly the wanted size.
      S_ARD: state_nxt = S_ACHK;
      S_ACHK: begin
        if (mem_rdata == NS_FREE) begin
          state_nxt = S_AMARK;
        end else if (eor) begin
          if (dtgt_r == '0) begin
            res_nxt.status = ST_NO_SPACE;
            state_nxt      = S_DONE;
          end else begin
            node_nxt  = NW'(1);
            depth_nxt = '0;
            bok_nxt   = 1'b0;
            state_nxt = S_BRD;
          end
        end else begin
          node_nxt  = node_r + NW'(1);
          state_nxt = S_ARD;
        end
      end
      // Look for the lowest-address larger free block.
      S_BRD: state_nxt = S_BCHK;
      S_BCHK: begin
        if (take) begin
          best_nxt   = node_r;
          baddr_nxt  = cur_addr;
          bdepth_nxt = depth_r;
          bok_nxt    = 1'b1;
        end
        if (eor && (depth_r + ORD_W'(1) == dtgt_r)) begin
          if (bok_r || take) begin
            node_nxt  = take ? node_r : best_r;
            depth_nxt = take ? depth_r : bdepth_r;
            state_nxt = S_SPLIT_P;
          end else begin
            res_nxt.status = ST_NO_SPACE;
            state_nxt      = S_DONE;
          end
        end else begin
          node_nxt  = node_r + NW'(1);
          if (eor) depth_nxt = depth_r + ORD_W'(1);
          state_nxt = S_BRD;
        end
      end
      // Halve the block, keeping the left half.
      S_SPLIT_P: begin
        mem_we    = 1'b1;
        mem_wdata = NS_SPLIT;
        state_nxt = S_SPLIT_L;
      end
      S_SPLIT_L: begin
        mem_we    = 1'b1;
        mem_waddr = node_r << 1;
        mem_wdata = NS_FREE;
        state_nxt = S_SPLIT_R;
      end
      S_SPLIT_R: begin
        mem_we    = 1'b1;
        mem_waddr = (node_r << 1) | NW'(1);
        mem_wdata = NS_FREE;
        node_nxt  = node_r << 1;
        depth_nxt = depth_r + ORD_W'(1);
        state_nxt = (depth_r + ORD_W'(1) == dtgt_r) ? S_AMARK : S_SPLIT_P;
      end
      S_AMARK: begin
        mem_we                = 1'b1;
        mem_wdata             = NS_ALLOC;
        res_nxt.status        = ST_GRANTED;
        res_nxt.block_address = 6'(grant_addr);
        res_nxt.block_order   = 3'(ord_r);
        res_nxt.unused_units  = 6'(unused);
        state_nxt             = S_DONE;
      end
      // Find the allocated block that starts at the given address.
      S_FRD: begin
        mem_raddr = fnode;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (f_aligned && (mem_rdata == NS_ALLOC)) begin
          res_nxt.status        = ST_FREED;
          res_nxt.block_address = faddr_r;
          res_nxt.block_order   = 3'(sh);
          node_nxt              = fnode;
          state_nxt             = S_MFREE;
        end else if (depth_r == ORD_W'(TOP)) begin
          res_nxt.status = ST_REJECTED;
          state_nxt      = S_DONE;
        end else begin
          depth_nxt = depth_r + ORD_W'(1);
          state_nxt = S_FRD;
        end
      end
      // Free the node, then merge with a free buddy going upward.
      S_MFREE: begin
        mem_we    = 1'b1;
        mem_wdata = NS_FREE;
        state_nxt = (node_r == NW'(1)) ? S_DONE : S_MRD;
      end
      S_MRD: begin
        mem_raddr = node_r ^ NW'(1);
        state_nxt = S_MCHK;
      end
      S_MCHK: state_nxt = (mem_rdata == NS_FREE) ? S_MABS_I : S_DONE;
      S_MABS_I: begin
        mem_we    = 1'b1;
        state_nxt = S_MABS_B;
      end
      S_MABS_B: begin
        mem_we    = 1'b1;
        mem_waddr = node_r ^ NW'(1);
        node_nxt  = node_r >> 1;
        state_nxt = S_MFREE;
      end
      // Hand the result over once the output register is free.
      S_DONE: begin
        if (rsp_free) begin
          stat.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res = res_r;

endmodule

>>> src/buddy_block_allocator.sv
// Buddy block allocator over a tree of per-node states. Request channel in,
// result channel out, one transaction each way per request.
//
// Usage: each request transaction allocates (rounded up to a power of two)
// or frees a block and yields exactly one result transaction. The block
// takes a request only when its sequencer is idle; in_if.ready shows that.
// The node tree sits in a RAM with one write and one registered read port,
// and every node visit takes a read step and then a check step, so the RAM
// port sets the time per request. An allocate scans for an exact-size
// block, else for the lowest-address larger one, then splits it down level
// by level. A free looks for the block level by level, then merges with
// free buddies level by level. Results sit in an output register, so a new
// request is taken while a result still waits; a stalled receiver holds
// the sequencer in its final step until the register empties.
// After reset the sequencer sweeps the whole node RAM to mark the root
// free; no request is taken during the sweep.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram and bba_seq.
`timescale 1ns / 1ps

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int TOTAL_UNITS = TOTAL_UNITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bba_req_if.sink   in_if,
  bba_rsp_if.source out_if
);

  localparam int TOP = $clog2(TOTAL_UNITS + 1) - 1;
  localparam int NW  = TOP + 1;

  seq_stat_t     stat;
  rsp_t          res;
  item_t         item;
  logic          start;
  logic          rsp_free;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic [NW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;
  logic          out_valid_r;
  rsp_t          out_data_r;

  assign item     = '{operation: in_if.operation, request_size: in_if.request_size,
                      free_address: in_if.free_address};
  assign start    = in_if.valid && stat.idle;
  assign rsp_free = !out_valid_r || out_if.ready;
  assign in_if.ready = stat.idle;

  bba_seq #(.TOTAL_UNITS(TOTAL_UNITS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .rsp_free  (rsp_free),
    .stat      (stat),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (node_t'(mem_rdata))
  );

  bba_ram #(.WIDTH(2), .DEPTH(2 ** NW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (2'(mem_wdata)),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads a finished result, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (stat.done) out_data_r <= res;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = 3'(out_data_r.status);
  assign out_if.block_address = out_data_r.block_address;
  assign out_if.block_order   = out_data_r.block_order;
  assign out_if.unused_units  = out_data_r.unused_units;

endmodule

>>> src/bba_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on bba_pkg and buddy_block_allocator.
`timescale 1ns / 1ps

module bba_checker
  import bba_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [5:0] block_address,
  input logic [2:0] block_order,
  input logic [5:0] unused_units
);

  // A stalled result holds its status and block address.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(block_address))
    else $error("result changed while stalled");

  // The block is busy in the cycle after it takes a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Failed requests carry zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == 3'(ST_NO_SPACE) || status == 3'(ST_REJECTED) ||
                  status == 3'(ST_BAD_SIZE))
    |-> block_address == '0 && block_order == '0 && unused_units == '0)
    else $error("failed result with nonzero fields");

  // A freed block reports no unused units.
  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == 3'(ST_FREED) |-> unused_units == '0)
    else $error("freed result with unused units");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .status        (out_if.status),
  .block_address (out_if.block_address),
  .block_order   (out_if.block_order),
  .unused_units  (out_if.unused_units)
);

>>> tb/tb_buddy_block_allocator.sv
// Self-checking testbench for the buddy block allocator: drives allocate and
// free requests, predicts each result from a node tree of its own, checks them.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and buddy_block_allocator.
`timescale 1ns / 1ps

module tb_buddy_block_allocator
  import bba_pkg::*;
();

  localparam int TOP_ORD = 6;
  localparam int WATCHDOG_LIMIT = 20000;

  // Expected result of one request.
  typedef struct packed {
    status_t    status;
    logic [5:0] block_address;
    logic [2:0] block_order;
    logic [5:0] unused_units;
  } grant_t;

  // Tree model and queue of pending results.
  class alloc_scoreboard;
    node_t  tree[128];
    grant_t pending[$];
    int     errors;

    function void clear_tree();
      foreach (tree[n]) tree[n] = NS_ABSENT;
      tree[1] = NS_FREE;
      errors = 0;
    endfunction

    function grant_t run_alloc(logic [6:0] req);
      grant_t g;
      int ord, d, best, best_addr, dep, a;
      g = '0;
      ord = 0;
      best = 0;
      best_addr = 1 << 30;
      if (req == 0 || req > 64) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      while ((1 << ord) < req) ord++;
      d = TOP_ORD - ord;
      for (int n = 1 << d; n < (2 << d); n++) begin
        if (tree[n] == NS_FREE) begin
          best = n;
          break;
        end
      end
      dep = d;
      if (best == 0) begin
        // Search every larger block for the lowest free address.
        for (int k = 0; k < d; k++) begin
          for (int n = 1 << k; n < (2 << k); n++) begin
            a = (n - (1 << k)) << (TOP_ORD - k);
            if (tree[n] == NS_FREE && a < best_addr) begin
              best_addr = a;
              best = n;
              dep = k;
            end
          end
        end
        if (best == 0) begin
          g.status = ST_NO_SPACE;
          return g;
        end
        while (dep < d) begin
          tree[best] = NS_SPLIT;
          tree[2*best] = NS_FREE;
          tree[2*best+1] = NS_FREE;
          best = 2 * best;
          dep++;
        end
      end
      tree[best] = NS_ALLOC;
      g.status = ST_GRANTED;
      g.block_address = 6'((best - (1 << d)) << ord);
      g.block_order = 3'(ord);
      g.unused_units = 6'((1 << ord) - req);
      return g;
    endfunction

    function grant_t run_free(logic [5:0] addr);
      grant_t g;
      int found, n, dd;
      g = '0;
      found = 0;
      dd = 0;
      for (int d = 0; d <= TOP_ORD; d++) begin
        if ((addr & ((1 << (TOP_ORD - d)) - 1)) != 0) continue;
        n = (1 << d) + (addr >> (TOP_ORD - d));
        if (tree[n] == NS_ALLOC) begin
          found = n;
          dd = d;
          break;
        end
      end
      if (found == 0) begin
        g.status = ST_REJECTED;
        return g;
      end
      g.status = ST_FREED;
      g.block_address = addr;
      g.block_order = 3'(TOP_ORD - dd);
      n = found;
      tree[n] = NS_FREE;
      // Merge free buddies upward.
      while (n > 1 && tree[n ^ 1] == NS_FREE) begin
        tree[n] = NS_ABSENT;
        tree[n ^ 1] = NS_ABSENT;
        n = n >> 1;
        tree[n] = NS_FREE;
      end
      return g;
    endfunction

    function void note_request(logic op, logic [6:0] req, logic [5:0] addr);
      if (op == OP_ALLOC) pending.push_back(run_alloc(req));
      else pending.push_back(run_free(addr));
    endfunction

    function void check_result(logic [2:0] st, logic [5:0] addr, logic [2:0] ord,
                               logic [5:0] unused);
      grant_t g;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      g = pending.pop_front();
      if (st != g.status) begin
        $error("status: expected %0d, actual %0d", g.status, st);
        errors++;
      end
      if (addr != g.block_address) begin
        $error("block_address: expected %0d, actual %0d", g.block_address, addr);
        errors++;
      end
      if (ord != g.block_order) begin
        $error("block_order: expected %0d, actual %0d", g.block_order, ord);
        errors++;
      end
      if (unused != g.unused_units) begin
        $error("unused_units: expected %0d, actual %0d", g.unused_units, unused);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bba_req_if in_if();
  bba_rsp_if out_if();
  alloc_scoreboard sb;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [5:0] live_addrs[$];

  always #5 clk = ~clk;

  buddy_block_allocator uut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  // Record accepted requests and check results at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_request(in_if.operation, in_if.request_size, in_if.free_address);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.block_address, out_if.block_order,
                        out_if.unused_units);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver stalls in a pattern of its own, with quiet stretches.
  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (($time / 3000) % 3 == 0) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // Send one request, with bursty gaps before it.
  task automatic send_request(logic op, logic [6:0] req, logic [5:0] addr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    // Raise valid on a falling edge of its own, after the previous drop.
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.request_size <= req;
    in_if.free_address <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op == OP_FREE) begin
      foreach (live_addrs[k]) begin
        if (live_addrs[k] == addr) begin
          live_addrs.delete(k);
          break;
        end
      end
    end
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [6:0] req;
    logic [5:0] addr;
    int pick;
    sb = new();
    sb.clear_tree();
    in_if.valid = 1'b0;
    in_if.operation = OP_ALLOC;
    in_if.request_size = '0;
    in_if.free_address = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bad sizes, whole memory, no space, frees good and bad.
    send_request(OP_ALLOC, 7'd0, 6'd0);
    send_request(OP_ALLOC, 7'd127, 6'd63);
    send_request(OP_ALLOC, 7'd65, 6'd0);
    send_request(OP_ALLOC, 7'd64, 6'd0);
    send_request(OP_ALLOC, 7'd1, 6'd0);
    send_request(OP_FREE, 7'd0, 6'd1);
    send_request(OP_FREE, 7'd127, 6'd0);
    send_request(OP_FREE, 7'd0, 6'd0);
    send_request(OP_ALLOC, 7'd1, 6'd0);
    send_request(OP_ALLOC, 7'd3, 6'd0);
    send_request(OP_ALLOC, 7'd5, 6'd0);
    send_request(OP_ALLOC, 7'd32, 6'd0);
    send_request(OP_ALLOC, 7'd17, 6'd0);
    send_request(OP_FREE, 7'd0, 6'd63);
    send_request(OP_FREE, 7'd0, 6'd4);
    send_request(OP_FREE, 7'd0, 6'd0);
    send_request(OP_FREE, 7'd0, 6'd8);
    send_request(OP_FREE, 7'd0, 6'd32);
    send_request(OP_FREE, 7'd0, 6'd0);
    send_request(OP_FREE, 7'd0, 6'd32);
    drain_results();

    // Random: mostly allocations and frees of live blocks, some noise.
    for (int k = 0; k < 400; k++) begin
      if (k == 200) drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        req = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64))
                                          : 7'($urandom_range(1, 8));
        if ($urandom_range(0, 30) == 0) req = 7'($urandom_range(65, 127));
        send_request(OP_ALLOC, req, 6'($urandom));
        if (sb.pending.size() != 0 &&
            sb.pending[sb.pending.size()-1].status == ST_GRANTED)
          live_addrs.push_back(sb.pending[sb.pending.size()-1].block_address);
      end else if (pick < 9 && live_addrs.size() != 0) begin
        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        send_request(OP_FREE, 7'($urandom), addr);
      end else begin
        send_request(OP_FREE, 7'($urandom), 6'($urandom));
      end
    end

    drain_results();
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
